@@ sv/owm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_pkg: shared types and constants of the one-wire bus master
// Command kinds, the classified command and the result word, plus the
// register map of the configuration port.
// ---------------------------------------------------------------------------
package owm_pkg;

   localparam int DATA_WIDTH      = 8;
   localparam int REG_WIDTH       = 10;
   localparam int REG_COUNT       = 8;
   localparam int REG_INDEX_WIDTH = 3;
   localparam int REQ_TDATA_WIDTH = 16;
   localparam int REQ_TUSER_WIDTH = 2;
   localparam int RSP_TDATA_WIDTH = 24;
   localparam int RESULT_WIDTH    = 21;

   typedef enum logic [REQ_TUSER_WIDTH-1:0] {
      REQ_TICK  = 2'd0,
      REQ_RESET = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   localparam logic [REG_INDEX_WIDTH-1:0] R_RST_LOW = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] R_PRES    = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] R_TAIL    = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] R_W1      = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] R_W0      = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] R_SLOT    = 3'd5;
   localparam logic [REG_INDEX_WIDTH-1:0] R_RLOW    = 3'd6;
   localparam logic [REG_INDEX_WIDTH-1:0] R_RSAMP   = 3'd7;

   localparam logic [REG_WIDTH-1:0] REG_RESET_VALS [REG_COUNT] = '{
      10'd480, 10'd140, 10'd350, 10'd10, 10'd60, 10'd70, 10'd6, 10'd15
   };

   typedef struct packed {
      logic                  is_tick;
      logic                  is_reset;
      logic                  is_write;
      logic                  is_read;
      logic [DATA_WIDTH-1:0] write_data;
      logic                  bus_level;
   } cmd_type;

   typedef struct packed {
      logic                  rejected;
      logic [DATA_WIDTH-1:0] crc_value;
      logic                  presence;
      logic [DATA_WIDTH-1:0] read_data;
      logic                  done_res;
      logic                  busy_res;
      logic                  bus_drive_low;
   } result_type;

endpackage
`default_nettype wire

@@ sv/one_wire_bus_master.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master driven by microsecond ticks
// Request channel (req_): one transaction per tick or command. tuser holds
// the kind (tick, reset pulse, write byte, read byte); tdata holds the byte
// to write and the sampled bus level.
// Response channel (rsp_): exactly one transaction per request, in order,
// carrying the bus drive level for the coming tick, busy, done, the last
// byte read, presence, the running CRC-8 and a rejected flag for a command
// that arrived while busy.
// Configuration port (csr_): eight timing registers written by index, each
// in ticks; write them only while the master is idle.
// A request is written into the queue, then taken by the sequencer into the
// result register, from which its response is presented. Throughput: one
// request per cycle while the response receiver does not stall; the
// sequencer updates its state once per taken command.
// Reset clears the queue, the sequencer and the response valid flag and loads
// the default timings. A stalled response receiver holds the result
// register; the two-entry queue keeps accepting until it is full.
// ---------------------------------------------------------------------------
module one_wire_bus_master #(
   parameter int COUNT_WIDTH = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // write_data[7:0], bus_level[8], zero fill
   input  wire logic [owm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // req_type[1:0]
   input  wire logic [owm_pkg::REQ_TUSER_WIDTH-1:0]  req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // bus_drive_low[0], busy_res[1], done_res[2], read_data[10:3],
   // presence[11], crc_value[19:12], rejected[20], zero fill
   output logic [owm_pkg::RSP_TDATA_WIDTH-1:0]       rsp_tdata,
   input  wire logic                                 csr_wen,
   input  wire logic [owm_pkg::REG_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [owm_pkg::REG_WIDTH-1:0]        csr_wdata
);
   import owm_pkg::*;

   logic       q_full, q_push, q_pop, q_valid;
   cmd_type    push_cmd, head_cmd;
   result_type result;

   owm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   owm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   owm_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = RSP_TDATA_WIDTH'(result);

endmodule
`default_nettype wire

@@ sv/owm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_front: request intake
// Accepts request transactions while the queue has room and decodes the
// request kind into a classified command.
// ---------------------------------------------------------------------------
module owm_front (
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [owm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   input  wire logic [owm_pkg::REQ_TUSER_WIDTH-1:0]  req_tuser,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output owm_pkg::cmd_type                          q_cmd
);
   import owm_pkg::*;

   req_kind_type kind;

   assign kind       = req_kind_type'(req_tuser);
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd            = '0;
      q_cmd.write_data = req_tdata[DATA_WIDTH-1:0];
      q_cmd.bus_level  = req_tdata[DATA_WIDTH];
      unique case (kind)
         REQ_TICK:  q_cmd.is_tick  = 1'b1;
         REQ_RESET: q_cmd.is_reset = 1'b1;
         REQ_WRITE: q_cmd.is_write = 1'b1;
         REQ_READ:  q_cmd.is_read  = 1'b1;
         default:   q_cmd.is_tick  = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

@@ sv/owm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_queue: two-entry command queue
// Decouples request intake from bus sequencing.
// ---------------------------------------------------------------------------
module owm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire owm_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output owm_pkg::cmd_type      head_cmd
);
   import owm_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ sv/owm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_back: bus sequencer
// Holds the timing registers, runs reset, write and read slots one command
// transaction per cycle unless the response channel stalls, and registers the result for it.
// ---------------------------------------------------------------------------
module owm_back #(
   parameter int COUNT_WIDTH = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [owm_pkg::REG_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [owm_pkg::REG_WIDTH-1:0]         csr_wdata,
   input  wire logic                                  q_valid,
   input  wire owm_pkg::cmd_type                      q_cmd,
   output logic                                       q_pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output owm_pkg::result_type                        rsp_result
);
   import owm_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
   localparam logic [REG_WIDTH-1:0] REG_MASK = REG_WIDTH'((1 << COUNT_WIDTH) - 1);

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_RST_LOW  = 6'b000010,
      PH_RST_WAIT = 6'b000100,
      PH_RST_TAIL = 6'b001000,
      PH_WRITE    = 6'b010000,
      PH_READ     = 6'b100000
   } phase_type;

   function automatic logic [DATA_WIDTH-1:0] crc8_byte(input logic [DATA_WIDTH-1:0] crc,
                                                        input logic [DATA_WIDTH-1:0] data);
      logic [DATA_WIDTH-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < DATA_WIDTH; k++) begin
         c = c[0] ? ((c >> 1) ^ 8'h8c) : (c >> 1);
      end
      return c;
   endfunction

   logic [REG_WIDTH-1:0]   cfg_ff [REG_COUNT];
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in, tick_inc;
   logic [2:0]             bit_ff, bit_in;
   logic [DATA_WIDTH-1:0]  shift_ff, shift_in;
   logic [DATA_WIDTH-1:0]  crc_ff, crc_in;
   logic                   pres_ff, pres_in;
   logic [DATA_WIDTH-1:0]  last_ff, last_in;
   logic                   rsp_valid_ff;
   result_type             result_ff, result_in;
   logic                   take;
   logic                   done, rej, drive;
   logic [CMP_WIDTH-1:0]   tick_x, tick_new_x, low_x;
   logic [CMP_WIDTH-1:0]   rst_low_x, pres_x, tail_x, w1_x, w0_x, slot_x, rlow_x, rs_x;
   logic                   slot_end;

   assign rst_low_x = CMP_WIDTH'(cfg_ff[R_RST_LOW] & REG_MASK);
   assign pres_x    = CMP_WIDTH'(cfg_ff[R_PRES]    & REG_MASK);
   assign tail_x    = CMP_WIDTH'(cfg_ff[R_TAIL]    & REG_MASK);
   assign w1_x      = CMP_WIDTH'(cfg_ff[R_W1]      & REG_MASK);
   assign w0_x      = CMP_WIDTH'(cfg_ff[R_W0]      & REG_MASK);
   assign slot_x    = CMP_WIDTH'(cfg_ff[R_SLOT]    & REG_MASK);
   assign rlow_x    = CMP_WIDTH'(cfg_ff[R_RLOW]    & REG_MASK);
   assign rs_x      = ((cfg_ff[R_RSAMP] & REG_MASK) == '0) ? CMP_WIDTH'(1)
                                                            : CMP_WIDTH'(cfg_ff[R_RSAMP] & REG_MASK);

   assign take       = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop      = take;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign tick_inc = tick_ff + COUNT_WIDTH'(1);
   assign tick_x   = CMP_WIDTH'(tick_inc);
   assign slot_end = (tick_x >= slot_x);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      crc_in   = crc_ff;
      pres_in  = pres_ff;
      last_in  = last_ff;
      done     = 1'b0;
      rej      = 1'b0;
      if (q_cmd.is_tick) begin
         if (phase_ff != PH_IDLE) begin
            tick_in = tick_inc;
         end
         unique case (phase_ff)
            PH_IDLE: ;
            PH_RST_LOW: begin
               if (tick_x >= rst_low_x) begin
                  phase_in = PH_RST_WAIT;
                  tick_in  = '0;
               end
            end
            PH_RST_WAIT: begin
               if (tick_x >= pres_x) begin
                  pres_in = !q_cmd.bus_level;
                  tick_in = '0;
                  if (tail_x == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_RST_TAIL;
                  end
               end
            end
            PH_RST_TAIL: begin
               if (tick_x >= tail_x) begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end
            end
            PH_WRITE: begin
               if (slot_end) begin
                  shift_in = shift_ff >> 1;
                  tick_in  = '0;
                  bit_in   = bit_ff + 3'd1;
                  if (bit_ff == 3'd7) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
            end
            PH_READ: begin
               if ((tick_x == rs_x) || (slot_end && (tick_x < rs_x))) begin
                  shift_in = {q_cmd.bus_level, shift_ff[DATA_WIDTH-1:1]};
               end
               if (slot_end) begin
                  tick_in = '0;
                  bit_in  = bit_ff + 3'd1;
                  if (bit_ff == 3'd7) begin
                     last_in  = shift_in;
                     crc_in   = crc8_byte(crc_ff, shift_in);
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end else if (phase_ff != PH_IDLE) begin
         rej = 1'b1;
      end else begin
         tick_in = '0;
         bit_in  = '0;
         if (q_cmd.is_reset) begin
            crc_in   = '0;
            pres_in  = 1'b0;
            phase_in = PH_RST_LOW;
         end else if (q_cmd.is_write) begin
            shift_in = q_cmd.write_data;
            phase_in = PH_WRITE;
         end else begin
            shift_in = '0;
            phase_in = PH_READ;
         end
      end
   end

   assign tick_new_x = CMP_WIDTH'(tick_in);
   assign low_x      = shift_in[0] ? w1_x : w0_x;

   always_comb begin
      unique case (phase_in)
         PH_RST_LOW: drive = 1'b1;
         PH_WRITE:   drive = (tick_new_x < low_x);
         PH_READ:    drive = (tick_new_x < rlow_x);
         default:    drive = 1'b0;
      endcase
   end

   always_comb begin
      result_in.bus_drive_low = drive;
      result_in.busy_res      = (phase_in != PH_IDLE);
      result_in.done_res      = done;
      result_in.read_data     = last_in;
      result_in.presence      = pres_in;
      result_in.crc_value     = crc_in;
      result_in.rejected      = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= REG_RESET_VALS[i];
         end
      end else if (csr_wen) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         crc_ff       <= '0;
         pres_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            crc_ff   <= crc_in;
            pres_ff  <= pres_in;
            last_ff  <= last_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/owm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_checker: port-level checks for the one-wire bus master
// Watches the response channel for handshake and result consistency.
// ---------------------------------------------------------------------------
module owm_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tready,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [owm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);
   import owm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1] && !rsp_tdata[20])
      else $error("completion reported while still busy or rejected");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[1])
      else $error("rejection reported while idle");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response valid or request blocked straight after reset");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
